// ----- rtl/gbsr_pkg.sv -----
package gbsr_pkg;

   // Destination rows are padded to a multiple of this many bytes.
   localparam int DST_ALIGN = 4;
   localparam int PAD_W     = (DST_ALIGN > 1) ? $clog2(DST_ALIGN) : 1;
   localparam int MAX_ALIGN = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLYPH_WIDTH  = 4'd0,
      CSR_GLYPH_HEIGHT = 4'd1,
      CSR_BPP_CODE     = 4'd2,
      CSR_SRC_ALIGN    = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BPP_1 = 2'd0,
      BPP_2 = 2'd1,
      BPP_4 = 2'd2,
      BPP_8 = 2'd3
   } bpp_type;

   typedef struct packed {
      logic [7:0] glyph_width;
      logic [7:0] glyph_height;
      bpp_type    bpp_code;
      logic [4:0] src_align;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_col;
      logic [7:0] src_col;
      logic [7:0] row_index;
      logic       nibble_phase;
      logic [3:0] held_nibble;
      logic [3:0] align_phase;
   } pos_type;

   // Up to two data bytes per input beat; each may close a row, which is then
   // followed by pad zero bytes.
   typedef struct packed {
      logic             d0_valid;
      logic [7:0]       d0;
      logic             end0;
      logic             glyph0;
      logic             d1_valid;
      logic [7:0]       d1;
      logic             end1;
      logic             glyph1;
      logic [PAD_W-1:0] pad;
   } plan_type;

endpackage

// ----- rtl/gbsr_req_if.sv -----
interface gbsr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;

   modport source (output valid, output src_byte, input ready);
   modport sink (input valid, input src_byte, output ready);
endinterface

// ----- rtl/gbsr_rsp_if.sv -----
interface gbsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dst_byte;
   logic       row_last;
   logic       glyph_last;

   modport source (output valid, output dst_byte, output row_last, output glyph_last,
                   input ready);
   modport sink (input valid, input dst_byte, input row_last, input glyph_last,
                 output ready);
endinterface

// ----- rtl/gbsr_csr_if.sv -----
interface gbsr_csr_if;
   logic                                    valid;
   logic                                    ready;
   gbsr_pkg::csr_index_type                 index;
   logic [gbsr_pkg::CSR_DAT_W-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gbsr_planner.sv -----
module gbsr_planner (
   input  logic               clock,
   input  logic               reset,
   input  gbsr_pkg::cfg_type  cfg,
   input  logic               clear,
   input  logic               advance,
   input  logic [7:0]         src_byte,
   output gbsr_pkg::plan_type plan
);
   import gbsr_pkg::*;

   pos_type    pos_ff;
   pos_type    pos_in;
   pos_type    pos_nx;

   logic [10:0] bits;
   logic [7:0]  natural;
   logic [9:0]  dst_stride;
   logic [4:0]  align;
   logic [7:0]  half;
   logic [7:0]  r1;
   logic [7:0]  r2;
   logic        last1;
   logic        last2;
   logic        empty;
   logic        nibble_mode;
   logic        simple_stride;
   logic [8:0]  sc1;
   logic [7:0]  oc1;
   logic        glyph_done;
   logic        wrap;
   logic        phase_top;

   assign bits          = {3'b000, cfg.glyph_width} << cfg.bpp_code;
   assign natural       = 8'((bits + 11'd7) >> 3);
   assign dst_stride    = ((10'(natural) + 10'(DST_ALIGN - 1)) / 10'(DST_ALIGN))
                          * 10'(DST_ALIGN);
   assign align         = (cfg.src_align > 5'(MAX_ALIGN)) ? 5'(MAX_ALIGN) : cfg.src_align;
   assign half          = {1'b0, cfg.glyph_width[7:1]};
   assign r1            = pos_ff.row_index + 8'd1;
   assign r2            = pos_ff.row_index + 8'd2;
   assign last1         = r1 >= cfg.glyph_height;
   assign last2         = r2 >= cfg.glyph_height;
   assign empty         = (cfg.glyph_height == 8'd0) || (natural == 8'd0);
   // Odd-width 4bpp rows packed without gaps share a byte between rows.
   assign nibble_mode   = (align == 5'd0) && (cfg.bpp_code == BPP_4) && cfg.glyph_width[0];
   assign simple_stride = (cfg.bpp_code == BPP_8) || (align <= 5'd1);
   assign sc1           = {1'b0, pos_ff.src_col} + 9'd1;
   assign oc1           = pos_ff.out_col + 8'd1;
   assign phase_top     = {1'b0, pos_ff.align_phase} == (align - 5'd1);
   assign wrap          = (sc1 >= {1'b0, natural}) && (simple_stride || phase_top);

   always_comb begin
      plan       = '0;
      plan.pad   = PAD_W'(dst_stride - 10'(natural));
      pos_nx     = pos_ff;
      glyph_done = 1'b0;
      if (!empty) begin
         if (nibble_mode) begin
            if (!pos_ff.nibble_phase) begin
               plan.d0_valid = 1'b1;
               if (pos_ff.out_col < half) begin
                  plan.d0        = src_byte;
                  pos_nx.out_col = oc1;
               end else begin
                  plan.d0            = {src_byte[7:4], 4'h0};
                  plan.end0          = 1'b1;
                  pos_nx.held_nibble = src_byte[3:0];
                  if (last1) begin
                     plan.glyph0 = 1'b1;
                     pos_nx      = '0;
                  end else begin
                     pos_nx.row_index    = r1;
                     pos_nx.out_col      = 8'd0;
                     pos_nx.nibble_phase = 1'b1;
                     // A one-pixel row: the low nibble alone makes the next row.
                     if (half == 8'd0) begin
                        plan.d1_valid       = 1'b1;
                        plan.d1             = {src_byte[3:0], 4'h0};
                        plan.end1           = 1'b1;
                        pos_nx.nibble_phase = 1'b0;
                        if (last2) begin
                           plan.glyph1 = 1'b1;
                           pos_nx      = '0;
                        end else begin
                           pos_nx.row_index = r2;
                        end
                     end
                  end
               end
            end else begin
               plan.d0_valid      = 1'b1;
               plan.d0            = {pos_ff.held_nibble, src_byte[7:4]};
               pos_nx.held_nibble = src_byte[3:0];
               pos_nx.out_col     = oc1;
               if (oc1 >= half) begin
                  plan.d1_valid       = 1'b1;
                  plan.d1             = {src_byte[3:0], 4'h0};
                  plan.end1           = 1'b1;
                  pos_nx.nibble_phase = 1'b0;
                  if (last1) begin
                     plan.glyph1 = 1'b1;
                     pos_nx      = '0;
                  end else begin
                     pos_nx.row_index = r1;
                     pos_nx.out_col   = 8'd0;
                  end
               end
            end
         end else begin
            if (pos_ff.src_col < natural) begin
               plan.d0_valid  = 1'b1;
               plan.d0        = src_byte;
               pos_nx.out_col = sc1[7:0];
               if (sc1 == {1'b0, natural}) begin
                  plan.end0 = 1'b1;
                  if (last1) begin
                     plan.glyph0 = 1'b1;
                     glyph_done  = 1'b1;
                  end else begin
                     pos_nx.row_index = r1;
                     pos_nx.out_col   = 8'd0;
                  end
               end
            end
            if (glyph_done) begin
               pos_nx = '0;
            end else if (wrap) begin
               pos_nx.src_col     = 8'd0;
               pos_nx.align_phase = 4'd0;
            end else begin
               pos_nx.src_col     = sc1[7:0];
               pos_nx.align_phase = phase_top ? 4'd0 : pos_ff.align_phase + 4'd1;
            end
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (clear) begin
         pos_in = '0;
      end else if (advance) begin
         pos_in = pos_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- rtl/gbsr_emitter.sv -----
module gbsr_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_valid,
   input  gbsr_pkg::plan_type plan,
   output logic               take,
   gbsr_rsp_if.source         rsp_bus
);
   import gbsr_pkg::*;

   plan_type         plan_ff;
   plan_type         plan_in;
   logic             busy_ff;
   logic             busy_in;
   logic             slot_ff;
   logic             slot_in;
   logic             pad_mode_ff;
   logic             pad_mode_in;
   logic [PAD_W-1:0] pad_left_ff;
   logic [PAD_W-1:0] pad_left_in;

   logic             cur_end;
   logic             cur_glyph;
   logic [7:0]       cur_byte;
   logic             more_slot;
   logic             pad_last;
   logic             pad_follows;
   logic             item_last;
   logic             beat;

   assign cur_end     = slot_ff ? plan_ff.end1   : plan_ff.end0;
   assign cur_glyph   = slot_ff ? plan_ff.glyph1 : plan_ff.glyph0;
   assign cur_byte    = slot_ff ? plan_ff.d1     : plan_ff.d0;
   assign more_slot   = !slot_ff && plan_ff.d1_valid;
   assign pad_last    = pad_left_ff == PAD_W'(1);
   assign pad_follows = cur_end && (plan_ff.pad != '0);
   assign item_last   = pad_mode_ff ? (pad_last && !more_slot) : (!more_slot && !pad_follows);
   assign beat        = busy_ff && rsp_bus.ready;
   assign take        = load_valid && (!busy_ff || (beat && item_last));

   always_comb begin
      rsp_bus.valid = busy_ff;
      if (pad_mode_ff) begin
         rsp_bus.dst_byte   = 8'h00;
         rsp_bus.row_last   = pad_last;
         rsp_bus.glyph_last = pad_last && cur_glyph;
      end else begin
         rsp_bus.dst_byte   = cur_byte;
         rsp_bus.row_last   = cur_end && !pad_follows;
         rsp_bus.glyph_last = cur_end && !pad_follows && cur_glyph;
      end
   end

   always_comb begin
      plan_in     = plan_ff;
      busy_in     = busy_ff;
      slot_in     = slot_ff;
      pad_mode_in = pad_mode_ff;
      pad_left_in = pad_left_ff;
      if (take) begin
         // A beat that only skips source padding never occupies the output.
         plan_in     = plan;
         busy_in     = plan.d0_valid;
         slot_in     = 1'b0;
         pad_mode_in = 1'b0;
         pad_left_in = plan.pad;
      end else if (beat) begin
         if (item_last) begin
            busy_in = 1'b0;
         end
         if (pad_mode_ff) begin
            if (pad_last) begin
               pad_mode_in = 1'b0;
               slot_in     = 1'b1;
            end else begin
               pad_left_in = pad_left_ff - PAD_W'(1);
            end
         end else if (pad_follows) begin
            pad_mode_in = 1'b1;
            pad_left_in = plan_ff.pad;
         end else begin
            slot_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         slot_ff     <= 1'b0;
         pad_mode_ff <= 1'b0;
         pad_left_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         slot_ff     <= slot_in;
         pad_mode_ff <= pad_mode_in;
         pad_left_ff <= pad_left_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

endmodule

// ----- rtl/glyph_bitmap_stride_repacker.sv -----
// Glyph bitmap stride repacker.
// req_bus carries the source bitmap of a glyph, one byte per beat; rsp_bus returns
// the bitmap with every row padded by zero bytes to a multiple of DST_ALIGN bytes,
// with row_last on the final padded byte of each row and glyph_last on the final
// byte of the glyph. Source row padding is read and dropped. csr_bus writes the
// glyph width, height, bits per pixel and source alignment; it is always ready,
// and a write to one of these four registers returns the position to the start
// of a glyph. Write it only while no beat is in flight.
// The first result of a source byte is offered once the byte has passed the input
// register and been loaded into the output sequencer. A source byte yields no beat,
// one beat, or up to 2*DST_ALIGN beats when it ends one or two rows. While rsp_bus
// is ready, the input register takes a byte every cycle and the output emits one
// beat a cycle, so the sustained rate is one byte per cycle for bytes that yield at
// most one beat; a byte that ends a row holds the input until the output sequencer
// has played out its padding. When rsp_bus stalls, the current beat holds and one
// further source byte is taken into the input register before req_bus.ready falls.
// Reset empties the pipeline, clears the position and sets the registers to
// width 0, height 0, 4 bits per pixel, source alignment 1.
module glyph_bitmap_stride_repacker (
   input  logic      clock,
   input  logic      reset,
   gbsr_req_if.sink  req_bus,
   gbsr_rsp_if.source rsp_bus,
   gbsr_csr_if.sink  csr_bus
);
   import gbsr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] in_byte_in;
   logic       csr_write;
   logic       cfg_clear;
   logic       take;
   plan_type   plan;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   assign req_bus.ready = !in_valid_ff || take;

   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (csr_write) begin
         unique case (csr_bus.index)
            CSR_GLYPH_WIDTH: begin
               cfg_in.glyph_width = csr_bus.data;
               cfg_clear          = 1'b1;
            end
            CSR_GLYPH_HEIGHT: begin
               cfg_in.glyph_height = csr_bus.data;
               cfg_clear           = 1'b1;
            end
            CSR_BPP_CODE: begin
               cfg_in.bpp_code = bpp_type'(csr_bus.data[1:0]);
               cfg_clear       = 1'b1;
            end
            CSR_SRC_ALIGN: begin
               cfg_in.src_align = csr_bus.data[4:0];
               cfg_clear        = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.src_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_width  <= 8'd0;
         cfg_ff.glyph_height <= 8'd0;
         cfg_ff.bpp_code     <= BPP_4;
         cfg_ff.src_align    <= 5'd1;
         in_valid_ff         <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   gbsr_planner u_planner (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .clear    (cfg_clear),
      .advance  (take),
      .src_byte (in_byte_ff),
      .plan     (plan)
   );

   gbsr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .plan       (plan),
      .take       (take),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ----- rtl/gbsr_checker.sv -----
module gbsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] dst_byte,
   input logic       row_last,
   input logic       glyph_last
);

   // Nothing is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // The end of a glyph is always the end of a row.
   a_glyph_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && glyph_last |-> row_last)
      else $error("glyph_last without row_last");

   // The input only backs up while the output has a beat to deliver.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with nothing to send");

   // A stalled beat holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(dst_byte) && $stable(row_last)
      && $stable(glyph_last))
      else $error("stalled beat changed");

   // An input that was ready and idle, with no result offered, stays ready.
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid && $past(req_ready) && !$past(req_valid) && !$past(rsp_valid)
      |-> req_ready)
      else $error("input not ready while idle");

endmodule

bind glyph_bitmap_stride_repacker gbsr_checker u_gbsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .dst_byte   (rsp_bus.dst_byte),
   .row_last   (rsp_bus.row_last),
   .glyph_last (rsp_bus.glyph_last)
);

// ----- test/glyph_bitmap_stride_repacker_tb.sv -----
module glyph_bitmap_stride_repacker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbsr_pkg::*;

   localparam int RANDOM_ITEMS  = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTED   = 40;

   typedef struct packed {
      logic [7:0] dst_byte;
      logic       row_last;
      logic       glyph_last;
   } rsp_beat_type;

   logic clock;
   logic reset;

   gbsr_req_if req_bus();
   gbsr_rsp_if rsp_bus();
   gbsr_csr_if csr_bus();

   glyph_bitmap_stride_repacker u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Register copy and position state of the repacking predictor.
   logic [7:0] cfg_width;
   logic [7:0] cfg_height;
   bpp_type    cfg_bpp;
   logic [4:0] cfg_align;
   int         col_out;
   int         col_src;
   int         rows_done;
   logic       odd_phase;
   logic [3:0] kept_nibble;

   rsp_beat_type expected_beats[$];
   rsp_beat_type step_beats[2*DST_ALIGN+2];
   int           step_count;

   int error_count   = 0;
   int src_beats     = 0;
   int rsp_beats     = 0;
   int settings_used = 0;
   int req_idle_pct  = 30;
   int rsp_idle_pct  = 30;
   int hold_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void clear_pos();
      col_out     = 0;
      col_src     = 0;
      rows_done   = 0;
      odd_phase   = 1'b0;
      kept_nibble = 4'h0;
   endfunction

   function automatic void put_beat(input logic [7:0] d);
      step_beats[step_count] = {d, 1'b0, 1'b0};
      step_count++;
   endfunction

   // Pads the row out to the destination stride and flags its end; true when the
   // glyph is complete.
   function automatic bit close_row(input int row_len, input int dst_stride);
      for (int i = row_len; i < dst_stride; i++) put_beat(8'h00);
      step_beats[step_count-1].row_last = 1'b1;
      col_out   = 0;
      rows_done = (rows_done + 1) & 255;
      if (rows_done >= int'(cfg_height)) begin
         step_beats[step_count-1].glyph_last = 1'b1;
         clear_pos();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void repack_byte(input logic [7:0] b);
      int  bpp_bits;
      int  bits;
      int  row_len;
      int  dst_stride;
      int  align;
      int  stride;
      int  half;
      bit  glyph_done;
      bpp_bits   = 1 << cfg_bpp;
      bits       = int'(cfg_width) * bpp_bits;
      row_len    = (bits + 7) / 8;
      dst_stride = (row_len + DST_ALIGN - 1) / DST_ALIGN * DST_ALIGN;
      align      = (cfg_align > 5'd16) ? 16 : int'(cfg_align);
      half       = int'(cfg_width) / 2;
      glyph_done = 1'b0;
      step_count = 0;
      if (cfg_height != 8'd0 && row_len != 0) begin
         if (align == 0 && bpp_bits == 4 && (bits % 8) != 0) begin
            // Odd-width packed 4bpp: every second row starts mid-byte.
            if (!odd_phase) begin
               if (col_out < half) begin
                  put_beat(b);
                  col_out++;
               end else begin
                  put_beat({b[7:4], 4'h0});
                  kept_nibble = b[3:0];
                  if (!close_row(row_len, dst_stride)) begin
                     odd_phase = 1'b1;
                     // With a width of one pixel the kept nibble is a whole row.
                     if (half == 0) begin
                        put_beat({kept_nibble, 4'h0});
                        odd_phase = 1'b0;
                        void'(close_row(row_len, dst_stride));
                     end
                  end
               end
            end else begin
               put_beat({kept_nibble, b[7:4]});
               kept_nibble = b[3:0];
               col_out++;
               if (col_out >= half) begin
                  put_beat({kept_nibble, 4'h0});
                  odd_phase = 1'b0;
                  void'(close_row(row_len, dst_stride));
               end
            end
         end else begin
            if (bpp_bits == 8 || align <= 1) stride = row_len;
            else stride = (row_len + align - 1) / align * align;
            if (col_src < row_len) begin
               put_beat(b);
               col_out = col_src + 1;
               if (col_src + 1 == row_len) glyph_done = close_row(row_len, dst_stride);
            end
            if (!glyph_done) begin
               col_src = col_src + 1;
               if (col_src >= stride) col_src = 0;
               col_src = col_src & 255;
            end
         end
      end
      for (int i = 0; i < step_count; i++) expected_beats.push_back(step_beats[i]);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Predictor updates and result checking, all sampled at the clock edge.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         cfg_width  = 8'd0;
         cfg_height = 8'd0;
         cfg_bpp    = BPP_4;
         cfg_align  = 5'd1;
         clear_pos();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_GLYPH_WIDTH: begin
                  cfg_width = csr_bus.data;
                  clear_pos();
               end
               CSR_GLYPH_HEIGHT: begin
                  cfg_height = csr_bus.data;
                  clear_pos();
               end
               CSR_BPP_CODE: begin
                  cfg_bpp = bpp_type'(csr_bus.data[1:0]);
                  clear_pos();
               end
               CSR_SRC_ALIGN: begin
                  cfg_align = csr_bus.data[4:0];
                  clear_pos();
               end
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            repack_byte(req_bus.src_byte);
            src_beats++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beats++;
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat dst_byte=%02h",
                                         rsp_bus.dst_byte));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_bus.dst_byte !== want.dst_byte)
                  report_mismatch($sformatf("dst_byte %02h, wanted %02h",
                                            rsp_bus.dst_byte, want.dst_byte));
               if (rsp_bus.row_last !== want.row_last)
                  report_mismatch($sformatf("row_last %b, wanted %b",
                                            rsp_bus.row_last, want.row_last));
               if (rsp_bus.glyph_last !== want.glyph_last)
                  report_mismatch($sformatf("glyph_last %b, wanted %b",
                                            rsp_bus.glyph_last, want.glyph_last));
            end
         end
      end
   end

   // Result sink: random stalls, plus a long hold-off on request.
   initial begin : rsp_sink
      int n;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            n = pick_gap(rsp_idle_pct);
            if (n != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Valid is only lowered when a gap follows, so back-to-back beats keep it high.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.src_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_beat(input csr_index_type idx, input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic set_config(input logic [7:0] w, input logic [7:0] h, input bpp_type bpp,
                             input logic [4:0] al);
      logic [5:0] junk_bpp;
      logic [2:0] junk_align;
      junk_bpp   = 6'($urandom);
      junk_align = 3'($urandom);
      write_beat(CSR_GLYPH_WIDTH, w);
      write_beat(CSR_GLYPH_HEIGHT, h);
      // Unused upper data bits are set at random; the block must ignore them.
      write_beat(CSR_BPP_CODE, {junk_bpp, bpp});
      write_beat(CSR_SRC_ALIGN, {junk_align, al});
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Waits for every expected beat, then lets beats that produce nothing clear out.
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_glyph();
      send_byte(8'h00);
      send_byte(8'hFF);
      drain_block();
   endtask

   task automatic test_single_pixel_rows();
      // A 4bpp glyph one pixel wide: one byte closes two rows.
      set_config(8'd1, 8'd3, BPP_4, 5'd0);
      send_byte(8'hFF);
      send_byte(8'h5A);
      drain_block();
   endtask

   task automatic test_odd_width_packing();
      set_config(8'd3, 8'd2, BPP_4, 5'd0);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      drain_block();
   endtask

   task automatic test_large_alignment();
      // An alignment above sixteen must behave as sixteen.
      set_config(8'd1, 8'd2, BPP_2, 5'd20);
      for (int i = 0; i < 17; i++) send_byte(8'($urandom));
      drain_block();
   endtask

   task automatic test_extreme_sizes();
      set_config(8'd255, 8'd255, BPP_8, 5'd31);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'($urandom));
      drain_block();
      // A write to an unknown index must leave the position alone.
      write_beat(csr_index_type'(4'($urandom_range(4, 15))), 8'($urandom));
      csr_bus.valid <= 1'b0;
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      drain_block();
   endtask

   task automatic test_output_backpressure();
      set_config(8'd8, 8'd4, BPP_8, 5'd1);
      req_idle_pct = 0;
      hold_cycles  = 150;
      for (int i = 0; i < 24; i++) send_byte(8'($urandom));
      drain_block();
      req_idle_pct = 30;
   endtask

   task automatic test_random_glyphs();
      int         counted;
      int         n;
      int         w;
      int         h;
      int         a;
      int         r;
      int         bits;
      int         row_len;
      int         stride;
      bpp_type    bpp;
      logic [4:0] al;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 5) w = 0;
         else if (r < 10) w = 255;
         else w = $urandom_range(1, 12);
         r = $urandom_range(0, 99);
         if (r < 5) h = 0;
         else if (r < 10) h = 255;
         else h = $urandom_range(1, 4);
         bpp = bpp_type'($urandom_range(0, 3));
         r = $urandom_range(0, 99);
         if (r < 35) al = 5'd0;
         else if (r < 50) al = 5'd1;
         else if (r < 85) al = 5'($urandom_range(2, 16));
         else al = 5'($urandom_range(17, 31));
         // Bias towards the packed odd-width 4bpp layout, the deepest path.
         if ($urandom_range(0, 9) < 3) begin
            bpp = BPP_4;
            al  = 5'd0;
            w   = 2 * $urandom_range(0, 5) + 1;
         end
         req_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         rsp_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         set_config(8'(w), 8'(h), bpp, al);

         bits    = w * (1 << bpp);
         row_len = (bits + 7) / 8;
         a       = (al > 5'd16) ? 16 : int'(al);
         if (h == 0 || row_len == 0) begin
            n = 3;
         end else begin
            if ($urandom_range(0, 9) < 6) begin
               if (a == 0 && bpp == BPP_4 && (bits % 8) != 0) begin
                  n = (h * w + 1) / 2;
               end else begin
                  stride = (bpp == BPP_8 || a <= 1) ? row_len
                                                    : (row_len + a - 1) / a * a;
                  n = (h - 1) * stride + row_len;
               end
               n = n * $urandom_range(1, 2);
               if (n > 40) n = 40;
            end else begin
               n = $urandom_range(1, 16);
            end
            counted += n;
         end
         for (int i = 0; i < n; i++) send_byte(8'($urandom));
         drain_block();
      end
      req_idle_pct = 30;
      rsp_idle_pct = 30;
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.src_byte <= 8'h00;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_GLYPH_WIDTH;
      csr_bus.data     <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_glyph();
      test_single_pixel_rows();
      test_odd_width_packing();
      test_large_alignment();
      test_extreme_sizes();
      test_output_backpressure();
      test_random_glyphs();

      drain_block();
      if (expected_beats.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
      $display("Sent %0d source beats under %0d register settings, checked %0d result beats.",
               src_beats, settings_used, rsp_beats);
      $display("Covered empty glyphs, packed odd-width 4bpp rows, wide alignments and stalls.");
      if (error_count == 0) begin
         $display("glyph_bitmap_stride_repacker_tb OK");
      end else begin
         $display("glyph_bitmap_stride_repacker_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Run timed out with %0d result beats outstanding.", expected_beats.size());
      $display("glyph_bitmap_stride_repacker_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gbsr_pkg.sv
rtl/gbsr_req_if.sv
rtl/gbsr_rsp_if.sv
rtl/gbsr_csr_if.sv
rtl/gbsr_planner.sv
rtl/gbsr_emitter.sv
rtl/glyph_bitmap_stride_repacker.sv
rtl/gbsr_checker.sv
test/glyph_bitmap_stride_repacker_tb.sv
